// ===== src/rbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants for the ray / box slab intersection block.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_W        = 48;
    localparam logic [46:0] TIME_MAX = 47'h7FFF_FFFF_FFFF;
    localparam int ADDR_W        = 5;

    typedef enum logic [2:0] {
        REG_LOW_X  = 3'd0,
        REG_LOW_Y  = 3'd1,
        REG_LOW_Z  = 3'd2,
        REG_HIGH_X = 3'd3,
        REG_HIGH_Y = 3'd4,
        REG_HIGH_Z = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        FACE_NEG_X = 3'd0,
        FACE_POS_X = 3'd1,
        FACE_NEG_Y = 3'd2,
        FACE_POS_Y = 3'd3,
        FACE_NEG_Z = 3'd4,
        FACE_POS_Z = 3'd5
    } face_t;

    // Per-ray data that rides alongside the dividers
    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [2:0]       dzero;
        logic [5:0]       tneg;
        logic             in_slabs;
    } side_t;

endpackage

// ===== src/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray against axis-aligned box by the slab method, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one ray per clock while the output is not stalled and returns one result
// per ray, in order: six parallel bit-per-stage dividers form the slab times,
// then five stages do the ordering, folding, the entry-point multiply, the
// add/saturate and the face pick, the last being the output register. A stall
// on the output side holds the whole pipeline. Box corners are APB registers at
// 4*i (low x,y,z then high x,y,z) and are to be written only while idle.
module ray_box_slab_intersect #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rbs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [31:0]        origin_x,
    input  logic signed [31:0]        origin_y,
    input  logic signed [31:0]        origin_z,
    input  logic signed [31:0]        direction_x,
    input  logic signed [31:0]        direction_y,
    input  logic signed [31:0]        direction_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      hit,
    output logic signed [31:0]        point_x,
    output logic signed [31:0]        point_y,
    output logic signed [31:0]        point_z,
    output logic [2:0]                face
);

    import rbs_pkg::*;

    localparam int NW = 33 + FRAC_BITS;
    localparam logic signed [TIME_W-1:0] TNEAR0 =
        -(TIME_W'(longint'(99999) <<< FRAC_BITS));
    localparam logic signed [TIME_W-1:0] TFAR0 =
        TIME_W'((longint'(999999) <<< FRAC_BITS) / 10);
    localparam logic [33:0] EPS = 34'(((longint'(1) <<< FRAC_BITS) + 999) / 1000);

    // ---------------- configuration ----------------
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic [2:0]         widx;

    assign pready = 1'b1;
    assign widx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= -32'sd32768;
                hi_reg[i] <= 32'sd32768;
            end
        end
        else if (psel && penable && pwrite)
        begin
            case (widx)
                REG_LOW_X:  lo_reg[0] <= pwdata;
                REG_LOW_Y:  lo_reg[1] <= pwdata;
                REG_LOW_Z:  lo_reg[2] <= pwdata;
                REG_HIGH_X: hi_reg[0] <= pwdata;
                REG_HIGH_Y: hi_reg[1] <= pwdata;
                REG_HIGH_Z: hi_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_LOW_X:  prdata = lo_reg[0];
            REG_LOW_Y:  prdata = lo_reg[1];
            REG_LOW_Z:  prdata = lo_reg[2];
            REG_HIGH_X: prdata = hi_reg[0];
            REG_HIGH_Y: prdata = hi_reg[1];
            REG_HIGH_Z: prdata = hi_reg[2];
            default:    prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic advance;
    logic e_vld_reg;

    assign advance  = !e_vld_reg || out_ready;
    assign in_ready = advance;

    // ---------------- entry: numerators, flags ----------------
    side_t              side_in;
    logic [32:0]        nmag [6];
    logic [31:0]        dmag [3];
    logic signed [31:0] org_in [3];
    logic signed [31:0] dir_in [3];

    assign org_in[0] = origin_x;
    assign org_in[1] = origin_y;
    assign org_in[2] = origin_z;
    assign dir_in[0] = direction_x;
    assign dir_in[1] = direction_y;
    assign dir_in[2] = direction_z;

    always_comb
    begin
        logic signed [32:0] nl;
        logic signed [32:0] nh;
        logic               ok;
        ok = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            nl = 33'(lo_reg[i]) - 33'(org_in[i]);
            nh = 33'(hi_reg[i]) - 33'(org_in[i]);
            nmag[2*i]   = nl[32] ? 33'(-nl) : 33'(nl);
            nmag[2*i+1] = nh[32] ? 33'(-nh) : 33'(nh);
            dmag[i]     = dir_in[i][31] ? 32'(-dir_in[i]) : 32'(dir_in[i]);
            side_in.org[i]   = org_in[i];
            side_in.dir[i]   = dir_in[i];
            side_in.dzero[i] = (dir_in[i] == 32'sd0);
            side_in.tneg[2*i]   = nl[32] ^ dir_in[i][31];
            side_in.tneg[2*i+1] = nh[32] ^ dir_in[i][31];
            if (dir_in[i] == 32'sd0 && (org_in[i] < lo_reg[i] || org_in[i] > hi_reg[i]))
            begin
                ok = 1'b0;
            end
        end
        side_in.in_slabs = ok;
    end

    // ---------------- dividers and side delay ----------------
    logic [NW-1:0] quo [6];
    logic          dv_vld_reg [NW];
    side_t         dv_side_reg [NW];

    for (genvar j = 0; j < 6; j++)
    begin : g_div
        rbs_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clk     (clk),
            .en      (advance),
            .num_mag (nmag[j]),
            .den_mag (dmag[j/2]),
            .quo     (quo[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NW; s++)
            begin
                dv_vld_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            dv_vld_reg[0] <= in_valid;
            for (int s = 1; s < NW; s++)
            begin
                dv_vld_reg[s] <= dv_vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_side_reg[0] <= side_in;
            for (int s = 1; s < NW; s++)
            begin
                dv_side_reg[s] <= dv_side_reg[s-1];
            end
        end
    end

    // ---------------- stage A: saturate, sign, order ----------------
    logic                      a_vld_reg;
    side_t                     a_side_reg;
    logic signed [TIME_W-1:0]  a_tmin_reg [3];
    logic signed [TIME_W-1:0]  a_tmax_reg [3];
    logic signed [TIME_W-1:0]  a_tmin_next [3];
    logic signed [TIME_W-1:0]  a_tmax_next [3];
    side_t                     dv_side;

    assign dv_side = dv_side_reg[NW-1];

    always_comb
    begin
        logic [63:0]              q64;
        logic [46:0]              qs;
        logic signed [TIME_W-1:0] t [6];
        for (int j = 0; j < 6; j++)
        begin
            q64  = 64'(quo[j]);
            qs   = (q64 > 64'(TIME_MAX)) ? TIME_MAX : q64[46:0];
            t[j] = dv_side.tneg[j] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
        end
        for (int i = 0; i < 3; i++)
        begin
            if (dv_side.dzero[i])
            begin
                a_tmin_next[i] = TNEAR0;
                a_tmax_next[i] = TFAR0;
            end
            else if (t[2*i] > t[2*i+1])
            begin
                a_tmin_next[i] = t[2*i+1];
                a_tmax_next[i] = t[2*i];
            end
            else
            begin
                a_tmin_next[i] = t[2*i];
                a_tmax_next[i] = t[2*i+1];
            end
        end
    end

    // ---------------- stage B: fold and hit ----------------
    logic                      b_vld_reg;
    side_t                     b_side_reg;
    logic                      b_hit_reg;
    logic signed [TIME_W-1:0]  b_tnear_reg;
    logic signed [TIME_W-1:0]  b_tnear_next;
    logic                      b_hit_next;

    always_comb
    begin
        logic signed [TIME_W-1:0] tf;
        b_tnear_next = TNEAR0;
        tf           = TFAR0;
        for (int i = 0; i < 3; i++)
        begin
            if (a_tmin_reg[i] > b_tnear_next)
            begin
                b_tnear_next = a_tmin_reg[i];
            end
            if (a_tmax_reg[i] < tf)
            begin
                tf = a_tmax_reg[i];
            end
        end
        b_hit_next = a_side_reg.in_slabs && !(b_tnear_next > tf) && !tf[TIME_W-1];
    end

    // ---------------- stage C: entry-point partial products ----------------
    logic          c_vld_reg;
    logic          c_hit_reg;
    logic [2:0][31:0] c_org_reg;
    logic [54:0]   c_hp_reg [3];
    logic [55:0]   c_lp_reg [3];
    logic [2:0]    c_sgn_reg;
    logic [54:0]   c_hp_next [3];
    logic [55:0]   c_lp_next [3];
    logic [2:0]    c_sgn_next;

    always_comb
    begin
        logic [46:0] ut;
        logic [31:0] ud;
        ut = b_tnear_reg[TIME_W-1] ? 47'(-b_tnear_reg) : b_tnear_reg[46:0];
        for (int i = 0; i < 3; i++)
        begin
            ud = b_side_reg.dir[i][31] ? 32'(-$signed(b_side_reg.dir[i]))
                                       : b_side_reg.dir[i];
            c_hp_next[i]  = 55'(ud) * 55'(ut[46:24]);
            c_lp_next[i]  = 56'(ud) * 56'(ut[23:0]);
            c_sgn_next[i] = b_side_reg.dir[i][31] ^ b_tnear_reg[TIME_W-1];
        end
    end

    // ---------------- stage D: shift, clamp, add, saturate ----------------
    logic               d_vld_reg;
    logic               d_hit_reg;
    logic signed [31:0] d_pt_reg [3];
    logic signed [31:0] d_pt_next [3];

    always_comb
    begin
        logic [63:0]        sum;
        logic [63:0]        sh;
        logic [40:0]        m;
        logic signed [42:0] p;
        logic signed [42:0] s;
        for (int i = 0; i < 3; i++)
        begin
            sum = {c_hp_reg[i][39:0], 24'b0} + 64'(c_lp_reg[i]);
            sh  = sum >> FRAC_BITS;
            if (c_hp_reg[i] >= 55'(64'd1 << 39) || sh > 64'(64'd1 << 40))
            begin
                m = 41'h100_0000_0000;
            end
            else
            begin
                m = sh[40:0];
            end
            p = c_sgn_reg[i] ? -$signed({2'b0, m}) : $signed({2'b0, m});
            s = 43'($signed(c_org_reg[i])) + p;
            if (s > 43'sd2147483647)
            begin
                d_pt_next[i] = 32'sh7FFF_FFFF;
            end
            else if (s < -43'sd2147483648)
            begin
                d_pt_next[i] = 32'sh8000_0000;
            end
            else
            begin
                d_pt_next[i] = s[31:0];
            end
        end
    end

    // ---------------- stage E: face pick, output register ----------------
    logic               e_hit_reg;
    logic signed [31:0] e_pt_reg [3];
    logic [2:0]         e_face_reg;
    face_t              e_face_next;

    always_comb
    begin
        logic signed [33:0] df [5];
        logic [33:0]        mg [5];
        df[0] = 34'(d_pt_reg[0]) - 34'(lo_reg[0]);
        df[1] = 34'(d_pt_reg[0]) - 34'(hi_reg[0]);
        df[2] = 34'(d_pt_reg[1]) - 34'(lo_reg[1]);
        df[3] = 34'(d_pt_reg[1]) - 34'(hi_reg[1]);
        df[4] = 34'(d_pt_reg[2]) - 34'(lo_reg[2]);
        for (int k = 0; k < 5; k++)
        begin
            mg[k] = df[k][33] ? 34'(-df[k]) : 34'(df[k]);
        end
        if (mg[0] < EPS)      e_face_next = FACE_NEG_X;
        else if (mg[1] < EPS) e_face_next = FACE_POS_X;
        else if (mg[2] < EPS) e_face_next = FACE_NEG_Y;
        else if (mg[3] < EPS) e_face_next = FACE_POS_Y;
        else if (mg[4] < EPS) e_face_next = FACE_NEG_Z;
        else                  e_face_next = FACE_POS_Z;
    end

    // ---------------- stage registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_vld_reg <= dv_vld_reg[NW-1];
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_side_reg  <= dv_side;
            a_tmin_reg  <= a_tmin_next;
            a_tmax_reg  <= a_tmax_next;
            b_side_reg  <= a_side_reg;
            b_tnear_reg <= b_tnear_next;
            b_hit_reg   <= b_hit_next;
            c_hit_reg   <= b_hit_reg;
            c_org_reg   <= b_side_reg.org;
            c_hp_reg    <= c_hp_next;
            c_lp_reg    <= c_lp_next;
            c_sgn_reg   <= c_sgn_next;
            d_hit_reg   <= c_hit_reg;
            d_pt_reg    <= d_pt_next;
            e_hit_reg   <= d_hit_reg;
            for (int i = 0; i < 3; i++)
            begin
                e_pt_reg[i] <= d_hit_reg ? d_pt_reg[i] : 32'sd0;
            end
            e_face_reg  <= d_hit_reg ? e_face_next : FACE_NEG_X;
        end
    end

    assign out_valid = e_vld_reg;
    assign hit       = e_hit_reg;
    assign point_x   = e_pt_reg[0];
    assign point_y   = e_pt_reg[1];
    assign point_z   = e_pt_reg[2];
    assign face      = e_face_reg;

endmodule

// ===== src/rbs_divider.sv =====
// ----------------------------------------------------------------------------
// rbs_divider
// Pipelined restoring divider, one quotient bit per stage. Dividend is the
// 33-bit magnitude shifted left by FRAC_BITS.
// ----------------------------------------------------------------------------
module rbs_divider #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [32:0]            num_mag,
    input  logic [31:0]            den_mag,
    output logic [33+FRAC_BITS-1:0] quo
);

    localparam int NW = 33 + FRAC_BITS;

    logic [NW-1:0] dvd_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [31:0]   rem_reg [NW];
    logic [31:0]   den_reg [NW];

    logic [NW-1:0] dvd_next [NW];
    logic [NW-1:0] quo_next [NW];
    logic [31:0]   rem_next [NW];
    logic [31:0]   den_next [NW];

    always_comb
    begin
        logic [NW-1:0] dv;
        logic [NW-1:0] qv;
        logic [31:0]   rv;
        logic [31:0]   dn;
        logic [32:0]   r;
        logic          ge;
        for (int s = 0; s < NW; s++)
        begin
            if (s == 0)
            begin
                dv = {num_mag, {FRAC_BITS{1'b0}}};
                qv = '0;
                rv = '0;
                dn = den_mag;
            end
            else
            begin
                dv = dvd_reg[s-1];
                qv = quo_reg[s-1];
                rv = rem_reg[s-1];
                dn = den_reg[s-1];
            end
            r  = {rv, dv[NW-1]};
            ge = (r >= {1'b0, dn});
            rem_next[s] = ge ? 32'(r - {1'b0, dn}) : r[31:0];
            quo_next[s] = {qv[NW-2:0], ge};
            dvd_next[s] = {dv[NW-2:0], 1'b0};
            den_next[s] = dn;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NW; s++)
            begin
                dvd_reg[s] <= dvd_next[s];
                quo_reg[s] <= quo_next[s];
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_next[s];
            end
        end
    end

    assign quo = quo_reg[NW-1];

endmodule

// ===== src/rbs_checker.sv =====
// ----------------------------------------------------------------------------
// rbs_checker
// Port-level checks for the ray / box slab intersection block.
// ----------------------------------------------------------------------------
module rbs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               hit,
    input logic signed [31:0] point_x,
    input logic signed [31:0] point_y,
    input logic signed [31:0] point_z,
    input logic [2:0]         face
);

    // a miss carries no point and no face
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> point_x == 0 && point_y == 0 && point_z == 0 && face == 0)
        else $error("miss beat with non-zero payload");

    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> face <= 3'd5)
        else $error("face code out of range");

    // a stalled result beat holds the whole pipeline
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(point_x)
            && $stable(face))
        else $error("stalled result beat changed");

endmodule

bind ray_box_slab_intersect rbs_checker u_rbs_checker (.*);
